>>> hw/rtl/smn_pkg.sv
// ----------------------------------------------------------------------------
// smn_pkg
// shared types, constants and helpers for the simon 32/64 cipher block
// ----------------------------------------------------------------------------
package smn_pkg;

    localparam int WORD_W     = 16;
    localparam int BLOCK_W    = 32;
    localparam int KEY_W      = 64;
    localparam int KEY_WORDS  = 4;
    localparam int ROUNDS_DEF = 32;
    localparam int Z_LEN      = 62;
    localparam int Z_IDX_W    = $clog2(Z_LEN);

    localparam logic [Z_LEN-1:0]  Z0_SEQ  = 62'h3E8958737D12B0E6;
    localparam logic [WORD_W-1:0] SCHED_C = 16'h0003;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        ST_EXPAND,
        ST_IDLE,
        ST_RUN
    } state_t;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // word window used while expanding the key schedule
    typedef struct packed {
        word_t w0;
        word_t w1;
        word_t w2;
        word_t w3;
    } key_window_t;

    function automatic word_t rol(input word_t v, input int s);
        rol = (v << s) | (v >> (WORD_W - s));
    endfunction

    function automatic word_t ror(input word_t v, input int s);
        ror = (v >> s) | (v << (WORD_W - s));
    endfunction

    function automatic word_t mix_f(input word_t x);
        mix_f = (rol(x, 1) & rol(x, 8)) ^ rol(x, 2);
    endfunction

    // published order, leftmost bit is index 0
    function automatic logic z0_bit(input logic [Z_IDX_W-1:0] idx);
        z0_bit = Z0_SEQ[Z_IDX_W'(Z_LEN - 1) - idx];
    endfunction

endpackage

>>> hw/rtl/smn_ram.sv
// ----------------------------------------------------------------------------
// smn_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module smn_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/smn_round.sv
// ----------------------------------------------------------------------------
// smn_round
// one simon round, forward for encryption or inverse for decryption
// ----------------------------------------------------------------------------
module smn_round
    import smn_pkg::*;
(
    input  logic  dec,
    input  word_t x_in,
    input  word_t y_in,
    input  word_t round_key,
    output word_t x_out,
    output word_t y_out
);

    always_comb
    begin
        if (dec == OP_DECRYPT)
        begin
            x_out = y_in;
            y_out = x_in ^ mix_f(y_in) ^ round_key;
        end
        else
        begin
            x_out = y_in ^ mix_f(x_in) ^ round_key;
            y_out = x_in;
        end
    end

endmodule

>>> hw/rtl/smn_key_step.sv
// ----------------------------------------------------------------------------
// smn_key_step
// one step of the m=4 key schedule from the last four round keys
// ----------------------------------------------------------------------------
module smn_key_step
    import smn_pkg::*;
(
    input  key_window_t         window,
    input  logic [Z_IDX_W-1:0]  z_idx,
    output word_t               new_key
);

    word_t t0;
    word_t t1;

    always_comb
    begin
        t0      = ror(window.w3, 3) ^ window.w1;
        t1      = t0 ^ ror(t0, 1);
        new_key = ~window.w0 ^ t1 ^ SCHED_C ^ {{(WORD_W-1){1'b0}}, z0_bit(z_idx)};
    end

endmodule

>>> hw/rtl/simon32_64_block_cipher.sv
// ----------------------------------------------------------------------------
// simon32_64_block_cipher
// iterative simon 32/64 core, one round per cycle from a round-key ram
//
//   channel   signals                                   transfer when
//   input     start, busy, opcode, data_block           start && !busy
//   result    result_valid, result_block                result_valid
//   config    cfg_valid, cfg_ready, cfg_data            cfg_valid && cfg_ready
//
// a block runs its rounds through the shared round unit and is accepted only
// from idle, so a new block is not taken until the last one has finished
// reset and every key write run a key expansion into the ram, busy and
// cfg_ready are held off meanwhile
// the result strobe lasts one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
module simon32_64_block_cipher
    import smn_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [BLOCK_W-1:0] data_block,
    output logic               result_valid,
    output logic [BLOCK_W-1:0] result_block,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [KEY_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(ROUNDS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ROUNDS - 1);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [KEY_W-1:0]   key_reg;
    logic               dec_reg;
    word_t              x_reg;
    word_t              y_reg;
    key_window_t        win_reg;
    logic               result_valid_reg;
    logic [BLOCK_W-1:0] result_block_reg;

    logic               item_xfer;
    logic               cfg_xfer;
    logic               last_step;
    logic [CNT_W-1:0]   step_next;
    logic [CNT_W-1:0]   raddr;
    word_t              rkey;
    word_t              sched_key;
    word_t              new_key;
    word_t              x_rnd;
    word_t              y_rnd;
    logic [Z_IDX_W-1:0] z_idx;

    assign item_xfer = start && !busy;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign last_step = (cnt_reg == LAST_CNT);
    assign step_next = cnt_reg + CNT_W'(1);
    assign z_idx     = Z_IDX_W'(cnt_reg) - Z_IDX_W'(KEY_WORDS);

    // round-key read address, issued the cycle before its key is used
    always_comb
    begin
        if (state_reg == ST_RUN)
        begin
            raddr = (dec_reg == OP_DECRYPT) ? (LAST_CNT - step_next) : step_next;
        end
        else
        begin
            raddr = (opcode == OP_DECRYPT) ? LAST_CNT : '0;
        end
    end

    smn_key_step u_key_step
    (
        .window  (win_reg),
        .z_idx   (z_idx),
        .new_key (sched_key)
    );

    always_comb
    begin
        if (cnt_reg < CNT_W'(KEY_WORDS))
        begin
            new_key = key_reg[WORD_W*cnt_reg[1:0] +: WORD_W];
        end
        else
        begin
            new_key = sched_key;
        end
    end

    smn_ram
    #(
        .WIDTH (WORD_W),
        .DEPTH (ROUNDS)
    )
    u_key_ram
    (
        .clk   (clk),
        .we    (state_reg == ST_EXPAND),
        .waddr (cnt_reg),
        .wdata (new_key),
        .raddr (raddr),
        .rdata (rkey)
    );

    smn_round u_round
    (
        .dec       (dec_reg),
        .x_in      (x_reg),
        .y_in      (y_reg),
        .round_key (rkey),
        .x_out     (x_rnd),
        .y_out     (y_rnd)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_EXPAND:
            begin
                cnt_next = step_next;
                if (last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                if (cfg_xfer)
                begin
                    state_next = ST_EXPAND;
                end
                else if (item_xfer)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cnt_next = step_next;
                if (last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // outputs, a pending block goes ahead of a key write
    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        cfg_ready = (state_reg == ST_IDLE) && !start;
    end

    assign result_valid = result_valid_reg;
    assign result_block = result_block_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_EXPAND;
            cnt_reg          <= '0;
            key_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= (state_reg == ST_RUN) && last_step;
            if (cfg_xfer)
            begin
                key_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXPAND)
        begin
            win_reg <= '{w0: win_reg.w1, w1: win_reg.w2, w2: win_reg.w3, w3: new_key};
        end
        if (item_xfer && !cfg_xfer)
        begin
            dec_reg <= opcode;
            x_reg   <= data_block[WORD_W-1:0];
            y_reg   <= data_block[BLOCK_W-1:WORD_W];
        end
        else if (state_reg == ST_RUN)
        begin
            x_reg <= x_rnd;
            y_reg <= y_rnd;
        end
        if ((state_reg == ST_RUN) && last_step)
        begin
            result_block_reg <= {y_rnd, x_rnd};
        end
    end

endmodule

>>> sim/simon32_64_block_cipher_test.sv
// ----------------------------------------------------------------------------
// simon32_64_block_cipher_test
// self-checking bench for the iterative simon 32/64 core: a scoreboard
// predicts every block from its own key schedule and round function, while
// tasks drive directed blocks, then random blocks under a series of keys
// (all zeros, all ones, random), with random sender gaps and bursts
// ----------------------------------------------------------------------------
module simon32_64_block_cipher_test;
    timeunit 1ns;
    timeprecision 1ps;

    import smn_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int TAIL_CYCLES   = 2 * ROUNDS_DEF + 8;
    localparam int PHASES        = 7;
    localparam int PHASE_BLOCKS  = 100;

    class cipher_scoreboard;
        bit [WORD_W-1:0]  round_key [ROUNDS_DEF];
        bit [BLOCK_W-1:0] expected_blocks [$];
        int               errors;

        function new();
            errors = 0;
            load_key('0);
        endfunction

        function bit [WORD_W-1:0] rot_left(bit [WORD_W-1:0] v, int s);
            return (v << s) | (v >> (WORD_W - s));
        endfunction

        function bit [WORD_W-1:0] rot_right(bit [WORD_W-1:0] v, int s);
            return (v >> s) | (v << (WORD_W - s));
        endfunction

        function bit [WORD_W-1:0] round_mix(bit [WORD_W-1:0] v);
            return (rot_left(v, 1) & rot_left(v, 8)) ^ rot_left(v, 2);
        endfunction

        // m=4 schedule, z0 read from its leftmost bit
        function void load_key(bit [KEY_W-1:0] key);
            bit [WORD_W-1:0] t;
            int              zi;
            for (int i = 0; i < KEY_WORDS; i++)
                round_key[i] = key[WORD_W*i +: WORD_W];
            for (int i = KEY_WORDS; i < ROUNDS_DEF; i++)
            begin
                zi = (i - KEY_WORDS) % Z_LEN;
                t  = rot_right(round_key[i-1], 3) ^ round_key[i-3];
                t  = t ^ rot_right(t, 1);
                round_key[i] = ~round_key[i-KEY_WORDS] ^ t ^ SCHED_C
                               ^ WORD_W'(Z0_SEQ[Z_LEN-1-zi]);
            end
        endfunction

        function bit [BLOCK_W-1:0] crypt_block(bit op, bit [BLOCK_W-1:0] blk);
            bit [WORD_W-1:0] x;
            bit [WORD_W-1:0] y;
            bit [WORD_W-1:0] n;
            x = blk[WORD_W-1:0];
            y = blk[BLOCK_W-1:WORD_W];
            if (op == OP_ENCRYPT)
            begin
                for (int r = 0; r < ROUNDS_DEF; r++)
                begin
                    n = y ^ round_mix(x) ^ round_key[r];
                    y = x;
                    x = n;
                end
            end
            else
            begin
                for (int r = ROUNDS_DEF - 1; r >= 0; r--)
                begin
                    n = x ^ round_mix(y) ^ round_key[r];
                    x = y;
                    y = n;
                end
            end
            return {y, x};
        endfunction

        function void note_block(bit op, bit [BLOCK_W-1:0] blk);
            expected_blocks.push_back(crypt_block(op, blk));
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_block(bit [BLOCK_W-1:0] got);
            bit [BLOCK_W-1:0] want;
            if (expected_blocks.size() == 0)
                report_mismatch($sformatf("result_block %h with no block pending", got));
            else
            begin
                want = expected_blocks.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("result_block %h, expected %h", got, want));
            end
        endtask

        function int pending();
            return expected_blocks.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               opcode;
    logic [BLOCK_W-1:0] data_block;
    logic               result_valid;
    logic [BLOCK_W-1:0] result_block;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [KEY_W-1:0]   cfg_data;

    cipher_scoreboard   sb;
    int                 idle_cycles = 0;

    simon32_64_block_cipher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .data_block   (data_block),
        .result_valid (result_valid),
        .result_block (result_block),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // transfer monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_block(result_block);
            if (start && !busy)
                sb.note_block(opcode, data_block);
            if (cfg_valid && cfg_ready)
                sb.load_key(cfg_data);
            if (result_valid || (start && !busy) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // called at a falling edge, returns at a falling edge
    task send_block(input logic op, input logic [BLOCK_W-1:0] blk, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        data_block <= blk;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task wait_drained();
        start <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    task write_key(input logic [KEY_W-1:0] key);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= key;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [KEY_W-1:0]   phase_key;
        logic [BLOCK_W-1:0] blk;
        logic               op;
        int                 gap;
        bit                 burst;

        sb         = new();
        rst_n      = 1'b0;
        start      = 1'b0;
        opcode     = OP_ENCRYPT;
        data_block = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // key from reset, before any write
        send_block(OP_ENCRYPT, 32'h0000_0000, 0);
        send_block(OP_DECRYPT, 32'h0000_0000, 0);
        send_block(OP_ENCRYPT, 32'hFFFF_FFFF, 3);
        send_block(OP_DECRYPT, 32'hFFFF_FFFF, 0);
        send_block(OP_ENCRYPT, 32'h0000_FFFF, 0);
        send_block(OP_DECRYPT, 32'hFFFF_0000, 1);

        // published test vector and its inverse
        write_key(64'h1918_1110_0908_0100);
        send_block(OP_ENCRYPT, 32'h6565_6877, 0);
        send_block(OP_DECRYPT, 32'hC69B_E9BB, 0);

        write_key('1);
        send_block(OP_ENCRYPT, 32'h0000_0000, 0);
        send_block(OP_DECRYPT, 32'h0000_0000, 0);
        send_block(OP_ENCRYPT, 32'hFFFF_FFFF, 0);
        send_block(OP_DECRYPT, 32'hFFFF_FFFF, 2);
        send_block(OP_ENCRYPT, 32'hAAAA_AAAA, 0);
        send_block(OP_DECRYPT, 32'h5555_5555, 0);

        write_key(64'hAAAA_AAAA_5555_5555);
        send_block(OP_ENCRYPT, 32'h8000_0001, 0);
        send_block(OP_DECRYPT, 32'h7FFF_FFFE, 0);

        burst = 1'b0;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       phase_key = '0;
                1:       phase_key = '1;
                default: phase_key = {$urandom, $urandom};
            endcase
            write_key(phase_key);
            for (int i = 0; i < PHASE_BLOCKS; i++)
            begin
                if (i % 20 == 0)
                    burst = ($urandom_range(0, 2) == 0);
                op = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 7))
                    0:       blk = '0;
                    1:       blk = '1;
                    2:       blk = 32'h1 << $urandom_range(0, BLOCK_W - 1);
                    default: blk = $urandom;
                endcase
                gap = burst ? 0 : $urandom_range(0, 16);
                send_block(op, blk, gap);
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
